/* design/configurable_crc16_engine_macros.svh */
// Assertion macros used by the CRC-16 engine checker.
`ifndef CONFIGURABLE_CRC16_ENGINE_MACROS_SVH
`define CONFIGURABLE_CRC16_ENGINE_MACROS_SVH

// Same-cycle implication, checked on clk, ignored while rst_n is low.
`define CRC16E_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc16e assertion failed");

// Next-cycle implication, checked on clk, ignored while rst_n is low.
`define CRC16E_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc16e assertion failed");

`endif

/* design/crc16e_pkg.sv */
// Types, register indexes and CRC helper functions for the CRC-16 engine.
`timescale 1ns / 1ps
`default_nettype none

package crc16e_pkg;

    localparam int CRC_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_POLY       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REFLECT_IN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REFLECT_OUT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SWAP_OUT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INVERT_OUT = 3'd5;

    localparam logic [CRC_W-1:0] POLY_RESET = 16'h1021;
    localparam logic [CRC_W-1:0] INIT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init;
        logic             reflect_in;
        logic             reflect_out;
        logic             swap_out;
        logic             invert_out;
    } cfg_t;

    function automatic logic [BYTE_W-1:0] flip8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int k = 0; k < BYTE_W; k++)
        begin
            r[k] = v[BYTE_W-1-k];
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] flip16(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++)
        begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

    // Fold one byte into the remainder: eight MSB-first shift steps.
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  rem,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] r;
        r = rem ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (r[CRC_W-1])
            begin
                r = {r[CRC_W-2:0], 1'b0} ^ poly;
            end
            else
            begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/configurable_crc16_engine.sv */
// Top level of the configurable CRC-16 engine.
// The engine takes one message byte per beat on the s_ side and keeps up with one
// beat every cycle while not stalled: a byte is held in the input register, then the
// whole eight-step fold runs through a combinational XOR network into the running
// remainder. A beat with tlast set moves on into the output register, which raises
// m_tvalid with its 16-bit CRC; the output register lets input continue while a
// result waits, until a second tlast byte meets a full, stalled output register.
// tuser marks the first byte of a message (the initial value replaces the remainder for it).
// Configuration writes take effect on the next cycle; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module configurable_crc16_engine (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration
    input  wire logic                                  cfg_we,
    input  wire logic [crc16e_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [crc16e_pkg::CRC_W-1:0]          cfg_wdata,
    // byte stream in
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [7:0]                            s_tdata,  // [7:0] message_byte
    input  wire logic                                  s_tuser,  // [0] first_byte
    input  wire logic                                  s_tlast,  // last_byte
    // CRC out
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [15:0]                           m_tdata   // [15:0] crc_value
);

    crc16e_pkg::cfg_t cfg_reg;

    logic                             in_valid_reg;
    logic [crc16e_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                             in_first_reg;
    logic                             in_last_reg;
    logic [crc16e_pkg::CRC_W-1:0]     rem_reg;
    logic                             out_valid_reg;
    logic [crc16e_pkg::CRC_W-1:0]     out_crc_reg;

    logic [crc16e_pkg::CRC_W-1:0]     rem_next;
    logic [crc16e_pkg::CRC_W-1:0]     crc_next;
    logic                             advance;
    logic                             in_take;

    crc16e_core u_core (
        .cfg     (cfg_reg),
        .rem     (rem_reg),
        .data    (in_byte_reg),
        .first   (in_first_reg),
        .rem_out (rem_next),
        .crc_out (crc_next)
    );

    // a last byte may only move on when the output slot is free or draining
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly        <= crc16e_pkg::POLY_RESET;
            cfg_reg.init        <= crc16e_pkg::INIT_RESET;
            cfg_reg.reflect_in  <= 1'b0;
            cfg_reg.reflect_out <= 1'b0;
            cfg_reg.swap_out    <= 1'b0;
            cfg_reg.invert_out  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                crc16e_pkg::CFG_POLY:        cfg_reg.poly        <= cfg_wdata;
                crc16e_pkg::CFG_INIT:        cfg_reg.init        <= cfg_wdata;
                crc16e_pkg::CFG_REFLECT_IN:  cfg_reg.reflect_in  <= cfg_wdata[0];
                crc16e_pkg::CFG_REFLECT_OUT: cfg_reg.reflect_out <= cfg_wdata[0];
                crc16e_pkg::CFG_SWAP_OUT:    cfg_reg.swap_out    <= cfg_wdata[0];
                crc16e_pkg::CFG_INVERT_OUT:  cfg_reg.invert_out  <= cfg_wdata[0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                rem_reg <= rem_next;
            end

            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_crc_reg <= crc_next;
        end
    end

endmodule

`default_nettype wire

/* design/crc16e_core.sv */
// Byte fold and output finishing network of the CRC-16 engine.
`timescale 1ns / 1ps
`default_nettype none

module crc16e_core (
    input  wire crc16e_pkg::cfg_t                      cfg,
    input  wire logic [crc16e_pkg::CRC_W-1:0]          rem,
    input  wire logic [crc16e_pkg::BYTE_W-1:0]         data,
    input  wire logic                                  first,
    output logic      [crc16e_pkg::CRC_W-1:0]          rem_out,
    output logic      [crc16e_pkg::CRC_W-1:0]          crc_out
);

    logic [crc16e_pkg::CRC_W-1:0]  rem_start;
    logic [crc16e_pkg::BYTE_W-1:0] data_in;
    logic [crc16e_pkg::CRC_W-1:0]  refl;
    logic [crc16e_pkg::CRC_W-1:0]  swapped;

    always_comb
    begin
        rem_start = first ? cfg.init : rem;
        data_in   = cfg.reflect_in ? crc16e_pkg::flip8(data) : data;
        rem_out   = crc16e_pkg::fold_byte(rem_start, data_in, cfg.poly);

        // finish: reflect, then byte swap, then invert
        refl    = cfg.reflect_out ? crc16e_pkg::flip16(rem_out) : rem_out;
        swapped = cfg.swap_out ? {refl[7:0], refl[15:8]} : refl;
        crc_out = cfg.invert_out ? ~swapped : swapped;
    end

endmodule

`default_nettype wire

/* design/crc16e_checker.sv */
// Port-level checker for the CRC-16 engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "configurable_crc16_engine_macros.svh"

module crc16e_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata
);

    // a waiting CRC beat holds its value
    `CRC16E_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // with the output slot empty the input side never stalls
    `CRC16E_ASSERT_NOW(a_in_free_when_out_empty, !m_tvalid, s_tready)

    // a draining output never backs up the input
    `CRC16E_ASSERT_NOW(a_in_free_when_out_drains, m_tready, s_tready)

    // a beat without tlast cannot produce a CRC beat from an empty output
    `CRC16E_ASSERT_NEXT(a_no_result_without_last,
        !m_tvalid && !s_tvalid && $past(!s_tvalid || !s_tready || !s_tlast), !m_tvalid)

endmodule

bind configurable_crc16_engine crc16e_checker u_crc16e_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
